>>> rtl/fcbs_pkg.sv
package fcbs_pkg;

  // Key for the first byte after the length byte, and the chain offset
  localparam logic [7:0] FIRST_KEY = 8'h89;
  localparam logic [7:0] CHAIN_ADD = 8'hDC;

  // Result queue depth: one slot more than the three results of a frame end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    logic       frame_short;
  } result_t;

  // Results produced by one request, in order, items[0] first
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     items;
  } push_t;

  // One application of the per-position rule
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] chain;
    logic [7:0] tenth;
  } rule_t;

endpackage

>>> rtl/fcbs_core.sv
module fcbs_core #(
  parameter int HEADER_BYTES    = 8,
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                frame_end,
  input  logic                mode,
  input  logic                room,
  output fcbs_pkg::push_t     push
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int HDR_W = $clog2(HEADER_BYTES + 7);
  localparam int CMP_W = (POS_W > HDR_W) ? POS_W : HDR_W;

  localparam logic [CMP_W-1:0] HDR1     = CMP_W'(HEADER_BYTES + 1);
  localparam logic [CMP_W-1:0] HDR2     = CMP_W'(HEADER_BYTES + 2);
  localparam logic [CMP_W-1:0] LONG_MIN = CMP_W'(HEADER_BYTES + 5);
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME_BYTES);

  // Input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_end;

  // Frame state
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       held0;
  logic [7:0]       held1;
  logic [7:0]       chain;
  logic [7:0]       chain_next;
  logic [7:0]       tenth;
  logic [7:0]       tenth_next;

  logic             fire;
  logic [CMP_W-1:0] p_ext;
  fcbs_pkg::rule_t  ra;
  fcbs_pkg::rule_t  rb;

  function automatic fcbs_pkg::rule_t apply_rule(
    input logic [7:0]       b,
    input logic [CMP_W-1:0] p,
    input logic [7:0]       c,
    input logic [7:0]       t,
    input logic             m
  );
    fcbs_pkg::rule_t o;
    o.r     = b;
    o.chain = c;
    o.tenth = t;
    if (p == HDR1) begin
      o.r     = ~b ^ fcbs_pkg::FIRST_KEY;
      o.chain = m ? o.r : b;
    end else if (p > HDR1) begin
      o.r = (c + fcbs_pkg::CHAIN_ADD) ^ b;
      if (p == HDR2) begin
        o.tenth = m ? b : o.r;
      end
      o.chain = m ? o.r : b;
    end
    return o;
  endfunction

  assign fire     = hold_valid && room;
  assign in_ready = !hold_valid || room;
  assign p_ext    = CMP_W'(pos);

  always_comb begin
    push       = '0;
    pos_next   = pos;
    chain_next = chain;
    tenth_next = tenth;
    ra         = apply_rule(held0, p_ext - CMP_W'(2), chain, tenth, mode);
    rb         = '0;
    if (!hold_end) begin
      if (p_ext >= CMP_W'(2)) begin
        push.count             = 2'd1;
        push.items[0].out_byte = ra.r;
        chain_next             = ra.chain;
        tenth_next             = ra.tenth;
      end
      pos_next = (pos < POS_MAX) ? pos + POS_W'(1) : pos;
    end else begin
      pos_next   = '0;
      chain_next = '0;
      tenth_next = '0;
      if (p_ext >= LONG_MIN) begin
        // tail: third-from-last keyed by plain byte ten, last two zeroed
        push.count               = 2'd3;
        push.items[0].out_byte   = held0 ^ tenth;
        push.items[2].frame_last = 1'b1;
      end else if (p_ext >= CMP_W'(2)) begin
        rb = apply_rule(held1, p_ext - CMP_W'(1), ra.chain, ra.tenth, mode);
        push.count                = 2'd3;
        push.items[0].out_byte    = ra.r;
        push.items[1].out_byte    = rb.r;
        push.items[2].out_byte    = hold_byte;
        push.items[2].frame_last  = 1'b1;
        push.items[2].frame_short = 1'b1;
      end else if (p_ext == CMP_W'(1)) begin
        rb = apply_rule(held1, '0, chain, tenth, mode);
        push.count                = 2'd2;
        push.items[0].out_byte    = rb.r;
        push.items[1].out_byte    = hold_byte;
        push.items[1].frame_last  = 1'b1;
        push.items[1].frame_short = 1'b1;
      end else begin
        push.count                = 2'd1;
        push.items[0].out_byte    = hold_byte;
        push.items[0].frame_last  = 1'b1;
        push.items[0].frame_short = 1'b1;
      end
    end
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= data_byte;
      hold_end  <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      chain <= '0;
      tenth <= '0;
    end else if (fire) begin
      pos   <= pos_next;
      chain <= chain_next;
      tenth <= tenth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !hold_end) begin
      held0 <= held1;
      held1 <= hold_byte;
    end
  end

endmodule

>>> rtl/fcbs_outq.sv
module fcbs_outq (
  input  logic            clk,
  input  logic            rst,
  input  fcbs_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            frame_last,
  output logic            frame_short
);

  fcbs_pkg::result_t                   slot [fcbs_pkg::QUEUE_DEPTH];
  logic [fcbs_pkg::QPTR_W-1:0]         head;
  logic [fcbs_pkg::QPTR_W-1:0]         tail;
  logic [fcbs_pkg::QCNT_W-1:0]         count;
  logic [fcbs_pkg::QCNT_W-1:0]         count_eff;
  logic                                pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign count_eff = count - fcbs_pkg::QCNT_W'(pop);
  // space for a full three-result request after this cycle's pop
  assign room      = count_eff <= fcbs_pkg::QCNT_W'(fcbs_pkg::QUEUE_DEPTH - 3);
  assign tail      = head + count[fcbs_pkg::QPTR_W-1:0];

  assign out_byte    = slot[head].out_byte;
  assign frame_last  = slot[head].frame_last;
  assign frame_short = slot[head].frame_short;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head + fcbs_pkg::QPTR_W'(pop);
      count <= count_eff + fcbs_pkg::QCNT_W'(push.count);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.count) begin
        slot[tail + fcbs_pkg::QPTR_W'(k)] <= push.items[k];
      end
    end
  end

endmodule

>>> rtl/frame_chained_byte_scrambler_unit.sv
// Path: a byte's own result passes the input register, then the result queue, after the
//   request that completes it; results lag input by two bytes.
// Throughput: one request per cycle on ordinary bytes while the queue has room; a
//   frame-end request yields up to three results through the one output, so input
//   pauses there while the queue drains, longer when results are held off.
// Reset (rst, synchronous): clears position, chain key, tenth plain byte, mode and queue.
module frame_chained_byte_scrambler_unit #(
  parameter int HEADER_BYTES    = 8,
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       frame_last,
  output logic       frame_short,
  // mode register: 0 descramble, 1 scramble
  input  logic       mode_we,
  input  logic       mode_wdata
);

  logic            mode;
  logic            room;
  fcbs_pkg::push_t push;

  // Mode register; the user must rewrite it only with no request in flight, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (mode_we) begin
      mode <= mode_wdata;
    end
  end

  // Per-byte transform: input register, frame state, keyed rules.
  // Two bytes are held back so the frame tail is known on frame end.
  fcbs_core #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .frame_end (frame_end),
    .mode      (mode),
    .room      (room),
    .push      (push)
  );

  // Result queue: absorbs the burst of up to three results per request
  // and keeps the request side moving while results wait.
  fcbs_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .frame_last  (frame_last),
    .frame_short (frame_short)
  );

endmodule

>>> dv/fcbs_result_checker.sv
module fcbs_result_checker #(
  parameter int HEADER_BYTES    = 8,
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       frame_last,
  input  logic       frame_short,
  input  logic       mode_we,
  input  logic       mode_wdata,
  output int         mismatches,
  output int         outstanding,
  output int         results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the block's frame state
  logic [9:0] position;
  logic [7:0] held [2];
  logic [7:0] chain_key;
  logic [7:0] tenth_plain;
  logic       scramble_mode;

  fcbs_pkg::result_t pending_results [$];

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // per-position whitening; advances the chain key as the block does
  function automatic logic [7:0] whiten(input logic [7:0] b, input int unsigned pos);
    logic [7:0] r;
    if (pos <= HEADER_BYTES) return b;
    if (pos == HEADER_BYTES + 1) begin
      r = ~b ^ fcbs_pkg::FIRST_KEY;
    end else begin
      r = (chain_key + fcbs_pkg::CHAIN_ADD) ^ b;
      if (pos == HEADER_BYTES + 2) tenth_plain = scramble_mode ? b : r;
    end
    chain_key = scramble_mode ? r : b;
    return r;
  endfunction

  function automatic void expect_result(input logic [7:0] b, input logic last,
                                        input logic shrt);
    fcbs_pkg::result_t r;
    r.out_byte    = b;
    r.frame_last  = last;
    r.frame_short = shrt;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_request(input logic [7:0] b, input logic fin);
    int unsigned p;
    int unsigned h;
    p = position;
    if (!fin) begin
      if (p >= 2) expect_result(whiten(held[0], p - 2), 1'b0, 1'b0);
      held[0] = held[1];
      held[1] = b;
      if (position < MAX_FRAME_BYTES) position = position + 1'b1;
    end else begin
      if (p + 1 >= HEADER_BYTES + 6 && p >= 2) begin
        // tail: keyed with the tenth plain byte, then two zero bytes
        expect_result(held[0] ^ tenth_plain, 1'b0, 1'b0);
        expect_result(8'h00, 1'b0, 1'b0);
        expect_result(8'h00, 1'b1, 1'b0);
      end else begin
        h = (p < 2) ? p : 2;
        for (int i = 0; i < h; i++)
          expect_result(whiten(held[2 - h + i], p - h + i), 1'b0, 1'b0);
        expect_result(b, 1'b1, 1'b1);
      end
      position    = '0;
      chain_key   = '0;
      tenth_plain = '0;
    end
  endfunction

  always @(posedge clk) begin
    fcbs_pkg::result_t want;
    if (rst) begin
      position        = '0;
      chain_key       = '0;
      tenth_plain     = '0;
      scramble_mode   = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      pending_results.delete();
    end else begin
      // a result can never belong to a request accepted on the same edge
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result byte %02h last %0b short %0b",
                           out_byte, frame_last, frame_short));
        end else begin
          want = pending_results.pop_front();
          if (out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", out_byte, want.out_byte));
          if (frame_last !== want.frame_last)
            report($sformatf("frame_last %0b, expected %0b", frame_last, want.frame_last));
          if (frame_short !== want.frame_short)
            report($sformatf("frame_short %0b, expected %0b", frame_short,
                             want.frame_short));
        end
      end
      if (mode_we) scramble_mode = mode_wdata;
      if (in_valid && in_ready) predict_request(data_byte, frame_end);
    end
    outstanding <= pending_results.size();
  end

endmodule

>>> dv/frame_chained_byte_scrambler_unit_test.sv
module frame_chained_byte_scrambler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEADER_BYTES    = 8;
  localparam int MAX_FRAME_BYTES = 512;
  // Watchdog limit, with ample margin over the slowest honest run
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_REQUESTS = 40;
  localparam int CHOKE_CYCLES    = 80;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte   = 8'h00;
  logic       frame_end   = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;
  logic       frame_last;
  logic       frame_short;
  logic       mode_we     = 1'b0;
  logic       mode_wdata  = 1'b0;

  int mismatches;
  int outstanding;
  int results_checked;

  // Stimulus bookkeeping, used for pacing and the closing summary
  bit   tx_quiet;
  bit   rx_quiet;
  int   choke_cycles;
  int   cycle_count;
  int   requests_sent;
  int   frames_sent;
  int   short_frames;
  int   mode_writes;
  logic mode_now;

  always #4 clk = ~clk;

  frame_chained_byte_scrambler_unit #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .frame_last  (frame_last),
    .frame_short (frame_short),
    .mode_we     (mode_we),
    .mode_wdata  (mode_wdata)
  );

  fcbs_result_checker #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_result_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .frame_end       (frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .frame_last      (frame_last),
    .frame_short     (frame_short),
    .mode_we         (mode_we),
    .mode_wdata      (mode_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // One request per call. A random gap (none in quiet stretches) comes first;
  // valid is only lowered when a gap follows, so back-to-back
  // requests keep valid high and just change the payload.
  task automatic send_request(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    frame_end <= fin;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Mode register write, only with the block drained. A frame's first two
  // bytes give no result, so spare cycles follow the last result.
  task automatic write_mode(input logic v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    mode_we    <= 1'b1;
    mode_wdata <= v;
    @(posedge clk);
    mode_we    <= 1'b0;
    mode_now    = v;
    mode_writes++;
  endtask

  // Random-content frame. With flip_inside the mode is swapped just after the
  // third byte past the header, while two bytes are still held back.
  task automatic send_frame(input int len, input bit flip_inside);
    frames_sent++;
    if (len < HEADER_BYTES + 6) short_frames++;
    for (int k = 0; k < len; k++) begin
      if (flip_inside && k == HEADER_BYTES + 3) write_mode(!mode_now);
      send_request(8'($urandom_range(0, 255)), k == len - 1);
    end
  endtask

  // Result side: its own random stalls, quiet stretches, and one long
  // hold-off on request from the stimulus.
  initial begin : result_sink
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (choke_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (choke_cycles) @(posedge clk);
        choke_cycles = 0;
      end
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [7:0] corner_bytes [14];
    int         target;
    int         len;

    corner_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                     8'h0E, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: shortest frame with the full tail rule, all-ones/all-zeros
    // bytes on the keyed positions, descrambling
    tx_quiet = 1'b0;
    write_mode(1'b0);
    frames_sent++;
    foreach (corner_bytes[k]) send_request(corner_bytes[k], k == 13);
    // single-byte frame: passes through marked short
    frames_sent++;
    short_frames++;
    send_request(8'hFF, 1'b1);

    // Scrambling: longest short frame, then a two-byte one
    write_mode(1'b1);
    send_frame(HEADER_BYTES + 5, 1'b0);
    send_frame(2, 1'b0);

    // Back-pressure: the receiver sits out a long stretch while requests keep
    // coming back to back, so the result queue fills and in_ready drops
    tx_quiet     = 1'b1;
    choke_cycles = CHOKE_CYCLES;
    send_frame(32, 1'b0);
    tx_quiet     = 1'b0;

    // Random frames, mostly long enough for the chain and tail rules
    target = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < target) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      tx_quiet = ($urandom_range(0, 2) == 0);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, HEADER_BYTES + 5)
                                        : $urandom_range(HEADER_BYTES + 6, 24);
      send_frame(len, len > HEADER_BYTES + 4 && $urandom_range(0, 5) == 0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests in %0d frames (%0d short, one under a long receive stall)",
             requests_sent, frames_sent, short_frames);
    $display("%0d results checked, %0d mode writes incl. a swap inside a frame",
             results_checked, mode_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fcbs_pkg.sv
rtl/fcbs_core.sv
rtl/fcbs_outq.sv
rtl/frame_chained_byte_scrambler_unit.sv
dv/fcbs_result_checker.sv
dv/frame_chained_byte_scrambler_unit_test.sv
